FILE: hdl/fast_inverse_sqrt_scale_assert.svh
// ---------------------------------------------------------------------------
// fast_inverse_sqrt_scale assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef FAST_INVERSE_SQRT_SCALE_ASSERT_SVH
`define FAST_INVERSE_SQRT_SCALE_ASSERT_SVH
`ifndef SYNTH
`define FISQ_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fisq assertion failed");
`define FISQ_ASSERT(lbl, prop) \
  `FISQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define FISQ_ASSERT_CLK(lbl, clk, rstn, prop)
`define FISQ_ASSERT(lbl, prop)
`endif
`endif

FILE: hdl/fisq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fisq_pkg
// Constants, stage types and binary32 multiply/subtract stage functions.
// ---------------------------------------------------------------------------
package fisq_pkg;

  localparam int unsigned PIPE_DEPTH = 19;

  localparam logic [31:0] RSQ_MAGIC       = 32'h5f3759df;
  localparam logic [31:0] F32_HALF        = 32'h3F000000;
  localparam logic [31:0] F32_ONE_HALF    = 32'h3FC00000;
  localparam logic [31:0] F32_QUIET_BIT   = 32'h00400000;
  localparam logic [31:0] F32_DEFAULT_NAN = 32'h7FC00000;
  localparam logic [31:0] F32_NEG_INF     = 32'hFF800000;

  typedef struct packed {
    logic               last;
    logic [31:0]        xb;
    logic               spec;
    logic [31:0]        spec_val;
    logic [31:0]        y;
    logic [31:0]        a;
  } ctx_t;

  typedef struct packed {
    logic               sign;
    logic               inf;
    logic               zero;
    logic signed [10:0] e;
    logic [47:0]        prod;
  } mul_a_t;

  typedef struct packed {
    logic               sign;
    logic               inf;
    logic               zero;
    logic signed [10:0] e;
    logic [47:0]        p;
  } mul_b_t;

  typedef struct packed {
    logic        sign;
    logic        inf;
    logic [8:0]  eb;
    logic [26:0] mb;
    logic [26:0] ms;
  } sub_a_t;

  typedef struct packed {
    logic        sign;
    logic        inf;
    logic [8:0]  eb;
    logic [26:0] diff;
  } sub_b_t;

  typedef struct packed {
    logic        sign;
    logic        inf;
    logic        zero;
    logic [7:0]  ef;
    logic [26:0] m;
  } sub_c_t;

  function automatic mul_a_t fmul_s1(input logic [31:0] a, input logic [31:0] b);
    mul_a_t r;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [10:0] ea;
    logic [10:0] eb;
    ea = (a[30:23] == 8'd0) ? 11'd1 : {3'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 11'd1 : {3'b0, b[30:23]};
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    r.sign = a[31] ^ b[31];
    r.inf  = (&a[30:23]) | (&b[30:23]);
    r.zero = (ma == 24'd0) | (mb == 24'd0);
    r.e    = $signed(ea + eb - 11'd127);
    r.prod = {24'd0, ma} * {24'd0, mb};
    return r;
  endfunction

  function automatic mul_b_t fmul_s2(input mul_a_t s);
    mul_b_t r;
    logic [5:0] lz;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (s.prod[i]) lz = 6'(47 - i);
    end
    r.sign = s.sign;
    r.inf  = s.inf;
    r.zero = s.zero;
    r.e    = s.e + 11'sd1 - $signed({5'd0, lz});
    r.p    = s.prod << lz;
    return r;
  endfunction

  function automatic logic [31:0] fmul_s3(input mul_b_t s);
    logic signed [10:0] tmp;
    logic [5:0]         sh;
    logic [47:0]        p;
    logic               st;
    logic [7:0]         ef;
    logic [30:0]        pk;
    logic               inc;
    logic [31:0]        res;
    tmp = 11'sd1 - s.e;
    sh  = 6'd0;
    p   = s.p;
    st  = 1'b0;
    ef  = s.e[7:0];
    if (s.e < 11'sd1) begin
      sh = (tmp > 11'sd48) ? 6'd48 : tmp[5:0];
      p  = s.p >> sh;
      st = |(s.p << (6'd48 - sh));
      ef = 8'd0;
    end
    inc = p[23] & (st | (|p[22:0]) | p[24]);
    pk  = {ef, p[46:24]} + {30'd0, inc};
    if (s.inf) begin
      res = {s.sign, 8'hFF, 23'd0};
    end else if (s.zero) begin
      res = {s.sign, 31'd0};
    end else if (s.e >= 11'sd255) begin
      res = {s.sign, 8'hFF, 23'd0};
    end else begin
      res = {s.sign, pk};
    end
    return res;
  endfunction

  // a - b for non-negative a and b
  function automatic sub_a_t fsub_s1(input logic [31:0] a, input logic [31:0] b);
    sub_a_t      r;
    logic        swap;
    logic [31:0] big;
    logic [31:0] sml;
    logic [8:0]  es;
    logic [8:0]  d;
    logic [26:0] ms;
    logic [26:0] shd;
    logic        st;
    swap = b[30:0] > a[30:0];
    big  = swap ? b : a;
    sml  = swap ? a : b;
    r.sign = swap;
    r.inf  = (&a[30:23]) | (&b[30:23]);
    r.eb   = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
    es     = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
    r.mb   = {|big[30:23], big[22:0], 3'b0};
    ms     = {|sml[30:23], sml[22:0], 3'b0};
    d      = r.eb - es;
    if (d >= 9'd27) begin
      shd = 27'd0;
      st  = |ms;
    end else begin
      shd = ms >> d[4:0];
      st  = |(ms << (5'd27 - d[4:0]));
    end
    r.ms = {shd[26:1], shd[0] | st};
    return r;
  endfunction

  function automatic sub_b_t fsub_s2(input sub_a_t s);
    sub_b_t r;
    r.sign = s.sign;
    r.inf  = s.inf;
    r.eb   = s.eb;
    r.diff = s.mb - s.ms;
    return r;
  endfunction

  function automatic sub_c_t fsub_s3(input sub_b_t s);
    sub_c_t     r;
    logic [4:0] lz;
    logic [8:0] lim;
    logic [4:0] sh;
    logic [8:0] e;
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (s.diff[i]) lz = 5'(26 - i);
    end
    lim = s.eb - 9'd1;
    sh  = ({4'd0, lz} > lim) ? lim[4:0] : lz;
    r.sign = s.sign;
    r.inf  = s.inf;
    r.zero = (s.diff == 27'd0);
    r.m    = s.diff << sh;
    e      = s.eb - {4'd0, sh};
    r.ef   = r.m[26] ? e[7:0] : 8'd0;
    return r;
  endfunction

  function automatic logic [31:0] fsub_s4(input sub_c_t s);
    logic        inc;
    logic [30:0] pk;
    logic [31:0] res;
    inc = s.m[2] & ((|s.m[1:0]) | s.m[3]);
    pk  = {s.ef, s.m[25:3]} + {30'd0, inc};
    if (s.inf) begin
      res = {s.sign, 8'hFF, 23'd0};
    end else if (s.zero) begin
      res = 32'd0;
    end else begin
      res = {s.sign, pk};
    end
    return res;
  endfunction

endpackage

FILE: hdl/fast_inverse_sqrt_scale.sv
`timescale 1ns / 1ps
// Streaming x * rsqrt_approx(x) on binary32 values. One request enters per
// clock while the output is not stalled; throughput is one per cycle, set by
// a 19-stage pipeline of five three-stage multipliers and one four-stage
// subtractor. A stall on the output freezes the whole pipeline.
// ---------------------------------------------------------------------------
// fast_inverse_sqrt_scale
// Magic-constant estimate, one Newton step, final scale by x.
// ---------------------------------------------------------------------------
`include "fast_inverse_sqrt_scale_assert.svh"

module fast_inverse_sqrt_scale (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        feature_valid_i,
  output logic        feature_ready_o,
  input  logic [31:0] feature_bits_i,
  input  logic        last_in_i,
  output logic        scaled_valid_o,
  input  logic        scaled_ready_i,
  output logic [31:0] scaled_bits_o,
  output logic        last_out_o
);

  localparam int unsigned N = fisq_pkg::PIPE_DEPTH;

  logic [N-1:0]     vld_q;
  fisq_pkg::ctx_t   ctx_q [N];
  fisq_pkg::ctx_t   ctx_d [N];
  fisq_pkg::mul_a_t ma_q  [5];
  fisq_pkg::mul_b_t mb_q  [5];
  fisq_pkg::sub_a_t sa_q;
  fisq_pkg::sub_b_t sb_q;
  fisq_pkg::sub_c_t sc_q;
  fisq_pkg::ctx_t   in_ctx;
  logic             pipe_en;
  logic             x_nan;
  logic             x_zero;
  logic             x_neg;
  logic             out_pos_fin;
  logic             out_neg_fin;

  assign pipe_en         = !vld_q[N-1] || scaled_ready_i;
  assign feature_ready_o = pipe_en;
  assign scaled_valid_o  = vld_q[N-1];
  assign scaled_bits_o   = ctx_q[N-1].a;
  assign last_out_o      = ctx_q[N-1].last;

  always_comb begin
    x_nan  = (&feature_bits_i[30:23]) && (feature_bits_i[22:0] != 23'd0);
    x_zero = feature_bits_i[30:0] == 31'd0;
    x_neg  = feature_bits_i[31];
    in_ctx.last = last_in_i;
    in_ctx.xb   = feature_bits_i;
    in_ctx.spec = x_nan || x_zero || x_neg;
    if (x_nan) begin
      in_ctx.spec_val = feature_bits_i | fisq_pkg::F32_QUIET_BIT;
    end else if (feature_bits_i == fisq_pkg::F32_NEG_INF) begin
      in_ctx.spec_val = fisq_pkg::F32_DEFAULT_NAN;
    end else begin
      in_ctx.spec_val = {feature_bits_i[31], 31'd0};
    end
    in_ctx.y = fisq_pkg::RSQ_MAGIC - {1'b0, feature_bits_i[31:1]};
    in_ctx.a = feature_bits_i;
  end

  always_comb begin
    ctx_d[0] = in_ctx;
    for (int k = 1; k < N; k++) begin
      ctx_d[k] = ctx_q[k-1];
    end
    // half = x * 0.5
    ctx_d[2].a   = fisq_pkg::fmul_s3(mb_q[0]);
    // t = half * y
    ctx_d[5].a   = fisq_pkg::fmul_s3(mb_q[1]);
    // t = t * y
    ctx_d[8].a   = fisq_pkg::fmul_s3(mb_q[2]);
    // u = 1.5 - t
    ctx_d[12].a  = fisq_pkg::fsub_s4(sc_q);
    // y = y * u
    ctx_d[15].y  = fisq_pkg::fmul_s3(mb_q[3]);
    // r = x * y
    ctx_d[N-1].a = ctx_q[N-2].spec ? ctx_q[N-2].spec_val
                                   : fisq_pkg::fmul_s3(mb_q[4]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[N-2:0], feature_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ctx_q   <= ctx_d;
      ma_q[0] <= fisq_pkg::fmul_s1(feature_bits_i, fisq_pkg::F32_HALF);
      mb_q[0] <= fisq_pkg::fmul_s2(ma_q[0]);
      ma_q[1] <= fisq_pkg::fmul_s1(ctx_q[2].a, ctx_q[2].y);
      mb_q[1] <= fisq_pkg::fmul_s2(ma_q[1]);
      ma_q[2] <= fisq_pkg::fmul_s1(ctx_q[5].a, ctx_q[5].y);
      mb_q[2] <= fisq_pkg::fmul_s2(ma_q[2]);
      sa_q    <= fisq_pkg::fsub_s1(fisq_pkg::F32_ONE_HALF, ctx_q[8].a);
      sb_q    <= fisq_pkg::fsub_s2(sa_q);
      sc_q    <= fisq_pkg::fsub_s3(sb_q);
      ma_q[3] <= fisq_pkg::fmul_s1(ctx_q[12].y, ctx_q[12].a);
      mb_q[3] <= fisq_pkg::fmul_s2(ma_q[3]);
      ma_q[4] <= fisq_pkg::fmul_s1(ctx_q[15].xb, ctx_q[15].y);
      mb_q[4] <= fisq_pkg::fmul_s2(ma_q[4]);
    end
  end

  assign out_pos_fin = scaled_valid_o && !ctx_q[N-1].spec && !(&ctx_q[N-1].xb[30:23]);
  assign out_neg_fin = scaled_valid_o && ctx_q[N-1].xb[31] && !(&ctx_q[N-1].xb[30:23]);

  `FISQ_ASSERT(a_accept_enters, (feature_valid_i && feature_ready_o) |=> vld_q[0])
  `FISQ_ASSERT(a_stall_freezes, !pipe_en |=> $stable(vld_q))
  `FISQ_ASSERT(a_pos_result_pos, out_pos_fin |-> !scaled_bits_o[31])
  `FISQ_ASSERT_CLK(a_neg_gives_negzero, clk_i, rst_ni, out_neg_fin |-> (scaled_bits_o == 32'h80000000))

endmodule

FILE: tb/sv/fast_inverse_sqrt_scale_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fast_inverse_sqrt_scale_tb
// Streams binary32 values with random gaps and output stalls. A directed
// table covers zeros, negatives, infinities, NaNs and the range extremes,
// then random values follow. Results are checked against known table values
// or an integer-exact binary32 model of estimate, Newton step and final scale.
// ---------------------------------------------------------------------------
module fast_inverse_sqrt_scale_tb;

  typedef struct {
    logic [31:0] bits;
    logic        last;
  } scaled_t;

  typedef struct {
    logic [31:0] bits;
    logic        last;
    bit          known;
    logic [31:0] want;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        feature_valid_i = 1'b0;
  logic        feature_ready_o;
  logic [31:0] feature_bits_i = '0;
  logic        last_in_i = 1'b0;
  logic        scaled_valid_o;
  logic        scaled_ready_i = 1'b0;
  logic [31:0] scaled_bits_o;
  logic        last_out_o;

  scaled_t pending_q[$];
  int      err_cnt = 0;
  bit      stim_done = 1'b0;

  fast_inverse_sqrt_scale uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // value = mant * 2^ex, rounded to nearest even binary32
  function automatic logic [31:0] round_pack(bit s, int ex, logic [63:0] mant);
    int           p;
    int           e;
    int           sh;
    logic [127:0] w;
    logic [63:0]  m;
    logic [63:0]  res;
    if (mant == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 64; i++) if (mant[i]) p = i;
    e = ex + p;
    if (e < -126) e = -126;
    sh = (e - 23) - ex;
    if (sh > 0) begin
      if (sh > 100) begin
        m = 0;
      end else begin
        w = {mant, 64'd0} >> sh;
        m = w[127:64];
        if (w[63:0] > 64'h8000_0000_0000_0000 ||
            (w[63:0] == 64'h8000_0000_0000_0000 && m[0])) m = m + 1;
      end
    end else begin
      m = mant << (-sh);
    end
    res = (64'(e + 126) << 23) + m;
    if (res >= 64'h7F80_0000) return {s, 8'hFF, 23'd0};
    return {s, res[30:0]};
  endfunction

  function automatic bit is_nan(logic [31:0] a);
    return (&a[30:23]) && (a[22:0] != 0);
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return (&a[30:23]) && (a[22:0] == 0);
  endfunction

  function automatic logic [23:0] sig_of(logic [31:0] a);
    return {|a[30:23], a[22:0]};
  endfunction

  function automatic int exp_of(logic [31:0] a);
    return ((a[30:23] == 0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    bit s;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | fisq_pkg::F32_QUIET_BIT;
    if (is_nan(b)) return b | fisq_pkg::F32_QUIET_BIT;
    if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0))
      return fisq_pkg::F32_DEFAULT_NAN;
    if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
    return round_pack(s, exp_of(a) + exp_of(b), 64'(sig_of(a)) * 64'(sig_of(b)));
  endfunction

  function automatic logic [63:0] align_sig(logic [31:0] a, int lo);
    logic [63:0] m;
    int          d;
    m = 64'(sig_of(a));
    d = lo - exp_of(a);
    if (d <= 0) return m << (-d);
    if (d >= 64) return 64'(m != 0);
    return (m >> d) | 64'((m & ((64'd1 << d) - 1)) != 0);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
    int     xa;
    int     xb;
    int     lo;
    longint sum;
    if (is_nan(a)) return a | fisq_pkg::F32_QUIET_BIT;
    if (is_nan(b)) return b | fisq_pkg::F32_QUIET_BIT;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fisq_pkg::F32_DEFAULT_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    xa = exp_of(a);
    xb = exp_of(b);
    lo = (xa < xb) ? xa : xb;
    if (lo < ((xa > xb) ? xa : xb) - 32) lo = ((xa > xb) ? xa : xb) - 32;
    sum = (a[31] ? -longint'(align_sig(a, lo)) : longint'(align_sig(a, lo))) +
          (b[31] ? -longint'(align_sig(b, lo)) : longint'(align_sig(b, lo)));
    if (sum == 0) return (a[31] && b[31]) ? 32'h8000_0000 : 32'd0;
    return round_pack(sum < 0, lo, 64'(sum < 0 ? -sum : sum));
  endfunction

  function automatic logic [31:0] predict_scaled(logic [31:0] xb);
    logic [31:0] y;
    logic [31:0] t;
    if (is_nan(xb)) return xb | fisq_pkg::F32_QUIET_BIT;
    if (xb[31] || xb[30:0] == 0) begin
      if (xb == fisq_pkg::F32_NEG_INF) return fisq_pkg::F32_DEFAULT_NAN;
      return {xb[31], 31'd0};
    end
    y = fisq_pkg::RSQ_MAGIC - (xb >> 1);
    t = f32_mul(f32_mul(f32_mul(xb, fisq_pkg::F32_HALF), y), y);
    y = f32_mul(y, f32_add(fisq_pkg::F32_ONE_HALF, {~t[31], t[30:0]}));
    return f32_mul(xb, y);
  endfunction

  task automatic send_value(logic [31:0] bits, logic last, bit known, logic [31:0] want);
    scaled_t exp_item;
    int      gap;
    gap = pick_gap();
    if (gap > 0) begin
      feature_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    feature_valid_i <= 1'b1;
    feature_bits_i  <= bits;
    last_in_i       <= last;
    do @(posedge clk_i); while (!(feature_valid_i && feature_ready_o));
    exp_item.bits = known ? want : predict_scaled(bits);
    exp_item.last = last;
    pending_q.push_back(exp_item);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    v = $urandom();
    if (r < 55) v[31] = 1'b0;
    else if (r < 65) v[30:23] = 8'd0;
    else if (r < 70) v[30:23] = 8'hFF;
    else if (r < 80) v[30:23] = 8'(127 + $signed($urandom_range(0, 16)) - 8);
    return v;
  endfunction

  vec_t dir_tbl[] = '{
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'hBF80_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{32'h8000_0001, 1'b0, 1'b1, 32'h8000_0000},
    '{32'hFF7F_FFFF, 1'b1, 1'b1, 32'h8000_0000},
    '{32'hFF80_0000, 1'b0, 1'b1, 32'h7FC0_0000},
    '{32'h7F80_0000, 1'b0, 1'b1, 32'hFF80_0000},
    '{32'h7F80_0001, 1'b1, 1'b1, 32'h7FC0_0001},
    '{32'hFFA0_0000, 1'b0, 1'b1, 32'hFFE0_0000},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h7FC0_0000, 1'b1, 1'b1, 32'h7FC0_0000},
    '{32'h3F80_0000, 1'b0, 1'b0, 32'h0},
    '{32'h4080_0000, 1'b0, 1'b0, 32'h0},
    '{32'h4000_0000, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h007F_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0080_0000, 1'b1, 1'b0, 32'h0},
    '{32'h7F7F_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h3F00_0000, 1'b1, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 1'b0, 32'h0}
  };

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tbl[i])
      send_value(dir_tbl[i].bits, dir_tbl[i].last, dir_tbl[i].known, dir_tbl[i].want);
    repeat (1100) send_value(rand_value(), 1'($urandom_range(0, 1)), 1'b0, 32'h0);
    feature_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        scaled_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      scaled_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    scaled_t exp_item;
    if (rst_ni && scaled_valid_o && scaled_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result scaled_bits=%h", scaled_bits_o);
        err_cnt++;
      end else begin
        exp_item = pending_q.pop_front();
        if (scaled_bits_o !== exp_item.bits) begin
          $error("scaled_bits expected %h actual %h", exp_item.bits, scaled_bits_o);
          err_cnt++;
        end
        if (last_out_o !== exp_item.last) begin
          $error("last_out expected %b actual %b", exp_item.last, last_out_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("fast_inverse_sqrt_scale_tb: PASS");
    end else begin
      $display("fast_inverse_sqrt_scale_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("fast_inverse_sqrt_scale_tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/fisq_pkg.sv
hdl/fast_inverse_sqrt_scale.sv
tb/sv/fast_inverse_sqrt_scale_tb.sv
